>>> design/lfe_pkg.sv
// Shared types and constants for the LIN frame byte engine.
package lfe_pkg;

    localparam logic [7:0] SYNC_BYTE  = 8'h55;
    localparam int         QDEPTH     = 4;
    localparam int         QAW        = $clog2(QDEPTH);
    localparam int         QCW        = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        REQ_HEADER = 2'd0,
        REQ_DATA   = 2'd1,
        REQ_BREAK  = 2'd2,
        REQ_RXBYTE = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        OUT_BREAK  = 2'd0,
        OUT_BYTE   = 2'd1,
        OUT_NOTIFY = 2'd2
    } t_out_kind;

    typedef enum logic [1:0] {
        CMD_HEADER   = 2'd0,
        CMD_DATA     = 2'd1,
        CMD_DATA_FIN = 2'd2,
        CMD_NOTIFY   = 2'd3
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind  kind;
        logic [7:0] a;
        logic [7:0] b;
    } t_cmd;

endpackage

>>> design/lin_frame_byte_engine.sv
// Top level of the LIN frame byte engine.
// One byte event is taken per clock while full is low; results leave one beat
// per clock while pop is high, through a single output register. In master mode
// a header yields three beats; a final data byte yields two (data then checksum)
// and any other event at most one. Events feed a four-entry command queue, so the
// input side keeps moving while the output side drains; the first result of an
// event passes through the queue and then the output register. Sustained
// throughput is bounded by the output register, one beat per cycle.
module lin_frame_byte_engine (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    input  logic       push,
    output logic       full,
    input  logic [1:0] i_req_type,
    input  logic [7:0] i_frame_id,
    input  logic       i_await_response,
    input  logic [7:0] i_data_byte,
    input  logic       i_final_data,
    output logic       empty,
    input  logic       pop,
    output logic [1:0] o_out_kind,
    output logic [7:0] o_out_byte,
    output logic       o_out_last
);
    import lfe_pkg::*;

    logic cmd_push;
    logic cmd_pop;
    logic cmd_full;
    logic cmd_empty;
    t_cmd cmd_in;
    t_cmd cmd_out;

    assign full = cmd_full;

    lfe_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_accept         (push & ~cmd_full),
        .i_req_type       (i_req_type),
        .i_frame_id       (i_frame_id),
        .i_await_response (i_await_response),
        .i_data_byte      (i_data_byte),
        .i_final_data     (i_final_data),
        .o_cmd_push       (cmd_push),
        .o_cmd            (cmd_in)
    );

    lfe_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (cmd_in),
        .i_pop   (cmd_pop),
        .o_full  (cmd_full),
        .o_empty (cmd_empty),
        .o_cmd   (cmd_out)
    );

    lfe_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_empty (cmd_empty),
        .i_cmd       (cmd_out),
        .o_cmd_pop   (cmd_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_out_kind  (o_out_kind),
        .o_out_byte  (o_out_byte),
        .o_out_last  (o_out_last)
    );

endmodule

>>> design/lfe_front.sv
// Front end: accepts byte events, keeps frame state, emits commands.
module lfe_front (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic         i_cfg_wdata,
    input  logic         i_accept,
    input  logic [1:0]   i_req_type,
    input  logic [7:0]   i_frame_id,
    input  logic         i_await_response,
    input  logic [7:0]   i_data_byte,
    input  logic         i_final_data,
    output logic         o_cmd_push,
    output lfe_pkg::t_cmd o_cmd
);
    import lfe_pkg::*;

    typedef enum logic [1:0] {
        HP_IDLE  = 2'd0,
        HP_DUMMY = 2'd1,
        HP_SYNC  = 2'd2,
        HP_ID    = 2'd3
    } t_hphase;

    logic       r_master;
    logic       r_listening, n_listening;
    logic [7:0] r_pending_id, n_pending_id;
    t_hphase    r_hphase, n_hphase;
    logic [7:0] r_sum, n_sum;

    logic [8:0] sum9;
    logic [7:0] sum_fold;
    logic       push;
    t_cmd       cmd;

    assign sum9     = {1'b0, r_sum} + {1'b0, i_data_byte};
    assign sum_fold = sum9[8] ? (sum9[7:0] + 8'd1) : sum9[7:0];

    always_comb begin
        n_listening  = r_listening;
        n_pending_id = r_pending_id;
        n_hphase     = r_hphase;
        n_sum        = r_sum;
        push         = 1'b0;
        cmd.kind     = CMD_DATA;
        cmd.a        = i_data_byte;
        cmd.b        = ~sum_fold;
        case (t_req'(i_req_type))
            REQ_HEADER: begin
                if (r_master) begin
                    push     = 1'b1;
                    cmd.kind = CMD_HEADER;
                    cmd.a    = i_frame_id;
                    n_sum    = 8'd0;
                    if (i_await_response) begin
                        n_pending_id = i_frame_id;
                        n_listening  = 1'b1;
                    end
                end
            end
            REQ_DATA: begin
                push = 1'b1;
                if (i_final_data) begin
                    cmd.kind = CMD_DATA_FIN;
                    n_sum    = 8'd0;
                end else begin
                    cmd.kind = CMD_DATA;
                    n_sum    = sum_fold;
                end
            end
            REQ_BREAK: begin
                if (!r_master) begin
                    n_hphase = HP_DUMMY;
                end
            end
            REQ_RXBYTE: begin
                if (r_master) begin
                    if (r_listening) begin
                        n_listening = 1'b0;
                        push        = 1'b1;
                        cmd.kind    = CMD_NOTIFY;
                        cmd.a       = r_pending_id;
                    end
                end else begin
                    case (r_hphase)
                        HP_DUMMY: n_hphase = HP_SYNC;
                        HP_SYNC:  n_hphase = (i_data_byte == SYNC_BYTE) ? HP_ID : HP_IDLE;
                        HP_ID: begin
                            n_hphase = HP_IDLE;
                            push     = 1'b1;
                            cmd.kind = CMD_NOTIFY;
                            cmd.a    = i_data_byte;
                        end
                        default: n_hphase = HP_IDLE;
                    endcase
                end
            end
            default: push = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_master     <= 1'b0;
            r_listening  <= 1'b0;
            r_pending_id <= 8'd0;
            r_hphase     <= HP_IDLE;
            r_sum        <= 8'd0;
        end else begin
            if (i_cfg_we) begin
                r_master <= i_cfg_wdata;
            end
            if (i_accept) begin
                r_listening  <= n_listening;
                r_pending_id <= n_pending_id;
                r_hphase     <= n_hphase;
                r_sum        <= n_sum;
            end
        end
    end

    assign o_cmd_push = i_accept & push;
    assign o_cmd      = cmd;

endmodule

>>> design/lfe_cmd_fifo.sv
// Short command queue between the front end and the result sequencer.
module lfe_cmd_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  lfe_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_empty,
    output lfe_pkg::t_cmd o_cmd
);
    import lfe_pkg::*;

    t_cmd             r_mem [QDEPTH];
    logic [QAW-1:0]   r_wr_ptr;
    logic [QAW-1:0]   r_rd_ptr;
    logic [QCW-1:0]   r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == QCW'(QDEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + QAW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + QAW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + QCW'(1);
                2'b01:   r_count <= r_count - QCW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCW'(QDEPTH))
        else $error("command queue count out of range");

    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wr_ptr - r_rd_ptr) == r_count[QAW-1:0])
        else $error("command queue pointers disagree with count");

    a_pop_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_pop && !do_push) |=> (r_count == $past(r_count) - QCW'(1)))
        else $error("command queue pop lost");

endmodule

>>> design/lfe_back.sv
// Back end: expands queued commands into result beats.
module lfe_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_empty,
    input  lfe_pkg::t_cmd i_cmd,
    output logic          o_cmd_pop,
    input  logic          i_pop,
    output logic          o_empty,
    output logic [1:0]    o_out_kind,
    output logic [7:0]    o_out_byte,
    output logic          o_out_last
);
    import lfe_pkg::*;

    logic       r_valid;
    logic [1:0] r_step;
    t_out_kind  r_kind;
    logic [7:0] r_byte;
    logic       r_last;

    logic       load;
    t_out_kind  n_kind;
    logic [7:0] n_byte;
    logic       n_last;

    assign load = ~i_cmd_empty & (~r_valid | i_pop);

    always_comb begin
        n_kind = OUT_BYTE;
        n_byte = i_cmd.a;
        n_last = 1'b1;
        case (i_cmd.kind)
            CMD_HEADER: begin
                case (r_step)
                    2'd0: begin
                        n_kind = OUT_BREAK;
                        n_byte = 8'd0;
                        n_last = 1'b0;
                    end
                    2'd1: begin
                        n_byte = SYNC_BYTE;
                        n_last = 1'b0;
                    end
                    default: n_byte = i_cmd.a;
                endcase
            end
            CMD_DATA_FIN: begin
                if (r_step == 2'd0) begin
                    n_last = 1'b0;
                end else begin
                    n_byte = i_cmd.b;
                end
            end
            CMD_NOTIFY: n_kind = OUT_NOTIFY;
            default:    n_kind = OUT_BYTE;
        endcase
    end

    assign o_cmd_pop = load & n_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_step  <= 2'd0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_step  <= n_last ? 2'd0 : (r_step + 2'd1);
            end else if (i_pop) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_kind <= n_kind;
            r_byte <= n_byte;
            r_last <= n_last;
        end
    end

    assign o_empty    = ~r_valid;
    assign o_out_kind = r_kind;
    assign o_out_byte = r_byte;
    assign o_out_last = r_last;

endmodule

>>> tb/tb_lin_frame_byte_engine.sv
// Testbench for lin_frame_byte_engine: directed and random byte events checked beat by beat.
module tb_lin_frame_byte_engine;
    import lfe_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] HP_IDLE  = 2'd0;
    localparam logic [1:0] HP_DUMMY = 2'd1;
    localparam logic [1:0] HP_SYNC  = 2'd2;
    localparam logic [1:0] HP_ID    = 2'd3;
    localparam int         HOLD_CYCLES  = 80;
    localparam int         SETTLE_CYCLES = 8;

    typedef enum int {RX_STEADY, RX_RANDOM, RX_PATTERN} t_rx_mode;

    typedef struct {
        t_out_kind  kind;
        logic [7:0] value;
        logic       last;
    } t_beat;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_we = 1'b0;
    logic       i_cfg_wdata = 1'b0;
    logic       push = 1'b0;
    logic       full;
    logic [1:0] i_req_type = 2'd0;
    logic [7:0] i_frame_id = 8'd0;
    logic       i_await_response = 1'b0;
    logic [7:0] i_data_byte = 8'd0;
    logic       i_final_data = 1'b0;
    logic       empty;
    logic       pop = 1'b0;
    logic [1:0] o_out_kind;
    logic [7:0] o_out_byte;
    logic       o_out_last;

    lin_frame_byte_engine dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .push             (push),
        .full             (full),
        .i_req_type       (i_req_type),
        .i_frame_id       (i_frame_id),
        .i_await_response (i_await_response),
        .i_data_byte      (i_data_byte),
        .i_final_data     (i_final_data),
        .empty            (empty),
        .pop              (pop),
        .o_out_kind       (o_out_kind),
        .o_out_byte       (o_out_byte),
        .o_out_last       (o_out_last)
    );

    // engine state as predicted
    logic       is_master;
    logic       listening;
    logic [7:0] pending_id;
    logic [1:0] header_phase;
    logic [7:0] checksum_acc;

    t_beat      pending_beats[$];
    int         errors = 0;
    int         items_sent = 0;
    int         beats_seen = 0;
    int         notifies_seen = 0;
    int         burst_left = 0;
    int         rx_tick = 0;
    int         hold_left = 0;
    bit         hold_req = 0;
    t_rx_mode   rx_mode = RX_STEADY;

    always #5 i_clk = ~i_clk;

    function void expect_beat(t_out_kind kind, logic [7:0] value, logic last);
        t_beat b;
        b.kind = kind;
        b.value = value;
        b.last = last;
        pending_beats.push_back(b);
    endfunction

    function void lin_engine_step(t_req req, logic [7:0] id, logic await_rsp,
                                  logic [7:0] data, logic fin);
        logic [8:0] sum;
        sum = {1'b0, checksum_acc} + {1'b0, data};
        if (sum >= 9'd256) sum = sum - 9'd255;
        case (req)
            REQ_HEADER: begin
                if (is_master) begin
                    expect_beat(OUT_BREAK, 8'h00, 1'b0);
                    expect_beat(OUT_BYTE, SYNC_BYTE, 1'b0);
                    expect_beat(OUT_BYTE, id, 1'b1);
                    checksum_acc = 8'h00;
                    if (await_rsp) begin
                        pending_id = id;
                        listening = 1'b1;
                    end
                end
            end
            REQ_DATA: begin
                if (fin) begin
                    expect_beat(OUT_BYTE, data, 1'b0);
                    expect_beat(OUT_BYTE, 8'hff - sum[7:0], 1'b1);
                    checksum_acc = 8'h00;
                end else begin
                    expect_beat(OUT_BYTE, data, 1'b1);
                    checksum_acc = sum[7:0];
                end
            end
            REQ_BREAK: begin
                if (!is_master) header_phase = HP_DUMMY;
            end
            default: begin
                if (is_master) begin
                    if (listening) begin
                        listening = 1'b0;
                        expect_beat(OUT_NOTIFY, pending_id, 1'b1);
                    end
                end else begin
                    case (header_phase)
                        HP_DUMMY: header_phase = HP_SYNC;
                        HP_SYNC:  header_phase = (data == SYNC_BYTE) ? HP_ID : HP_IDLE;
                        HP_ID: begin
                            header_phase = HP_IDLE;
                            expect_beat(OUT_NOTIFY, data, 1'b1);
                        end
                        default: ;
                    endcase
                end
            end
        endcase
    endfunction

    // receiver: own stall pattern plus a long counted hold-off on request
    always @(posedge i_clk) begin
        rx_tick++;
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
        end else begin
            case (rx_mode)
                RX_STEADY: pop <= 1'b1;
                RX_RANDOM: pop <= ($urandom_range(0, 3) != 0);
                default:   pop <= ((rx_tick % 7) < 4);
            endcase
        end
    end

    // inputs only move at posedge, so the falling edge sees the beat that the next edge takes
    always @(negedge i_clk) begin
        t_beat b;
        if (i_rst_n && pop && !empty) begin
            beats_seen++;
            if (pending_beats.size() == 0) begin
                errors++;
                $display("%0t: unexpected beat kind %0d byte %02h last %0d", $time,
                         o_out_kind, o_out_byte, o_out_last);
            end else begin
                b = pending_beats.pop_front();
                if (b.kind == OUT_NOTIFY) notifies_seen++;
                if (o_out_kind !== b.kind) begin
                    errors++;
                    $display("%0t: out_kind expected %0d actual %0d", $time, b.kind, o_out_kind);
                end
                if (o_out_byte !== b.value) begin
                    errors++;
                    $display("%0t: out_byte expected %02h actual %02h", $time, b.value,
                             o_out_byte);
                end
                if (o_out_last !== b.last) begin
                    errors++;
                    $display("%0t: out_last expected %0d actual %0d", $time, b.last, o_out_last);
                end
            end
        end
    end

    // called right after a rising edge; leaves push high for a following item
    task automatic send_item(t_req req, logic [7:0] id, logic await_rsp, logic [7:0] data,
                             logic fin);
        bit taken;
        taken = 0;
        push <= 1'b1;
        i_req_type <= req;
        i_frame_id <= id;
        i_await_response <= await_rsp;
        i_data_byte <= data;
        i_final_data <= fin;
        while (!taken) begin
            @(negedge i_clk);
            if (!full) begin
                lin_engine_step(req, id, await_rsp, data, fin);
                items_sent++;
                taken = 1;
            end
            @(posedge i_clk);
        end
    endtask

    task automatic idle(int cycles);
        push <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        push <= 1'b0;
        while (pending_beats.size() != 0 && guard < 5000) begin
            @(posedge i_clk);
            guard++;
        end
        if (pending_beats.size() != 0) begin
            errors += pending_beats.size();
            $display("%0t: %0d beats expected, 0 received", $time, pending_beats.size());
            pending_beats.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_mode(logic master);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= master;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        is_master = master;
    endtask

    task automatic pace();
        if (burst_left == 0) begin
            idle($urandom_range(1, 8));
            burst_left = $urandom_range(1, 12);
        end else begin
            burst_left--;
        end
    endtask

    function automatic logic [7:0] rnd8();
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_random_data(int count);
        for (int k = 0; k < count; k++) begin
            send_item(REQ_DATA, rnd8(), 1'($urandom), rnd8(), k == count - 1);
            pace();
        end
    endtask

    task automatic send_noise();
        send_item(t_req'($urandom_range(0, 3)), rnd8(), 1'($urandom), rnd8(), 1'($urandom));
        pace();
    endtask

    task automatic master_frame();
        logic aw;
        aw = ($urandom_range(0, 2) != 0);
        send_item(REQ_HEADER, rnd8(), aw, rnd8(), 1'($urandom));
        pace();
        send_random_data($urandom_range(1, 8));
        if (aw || $urandom_range(0, 3) == 0) begin
            send_item(REQ_RXBYTE, rnd8(), 1'($urandom), rnd8(), 1'($urandom));
            pace();
        end
    endtask

    task automatic slave_frame();
        logic [7:0] sync;
        sync = ($urandom_range(0, 4) != 0) ? SYNC_BYTE : rnd8();
        send_item(REQ_BREAK, rnd8(), 1'($urandom), rnd8(), 1'($urandom));
        pace();
        send_item(REQ_RXBYTE, rnd8(), 1'($urandom), rnd8(), 1'($urandom));
        pace();
        if ($urandom_range(0, 9) == 0) begin
            send_item(REQ_BREAK, rnd8(), 1'($urandom), rnd8(), 1'($urandom));
            pace();
            send_item(REQ_RXBYTE, rnd8(), 1'($urandom), rnd8(), 1'($urandom));
            pace();
        end
        send_item(REQ_RXBYTE, rnd8(), 1'($urandom), sync, 1'($urandom));
        pace();
        send_item(REQ_RXBYTE, rnd8(), 1'($urandom), rnd8(), 1'($urandom));
        pace();
        send_random_data($urandom_range(1, 8));
    endtask

    task automatic test_slave_header();
        set_mode(1'b0);
        send_item(REQ_RXBYTE, 8'h00, 1'b0, 8'h11, 1'b0);
        send_item(REQ_HEADER, 8'hff, 1'b1, 8'h00, 1'b1);
        send_item(REQ_BREAK, 8'h00, 1'b0, 8'h00, 1'b0);
        send_item(REQ_RXBYTE, 8'h00, 1'b0, 8'h00, 1'b0);
        send_item(REQ_RXBYTE, 8'h00, 1'b0, SYNC_BYTE, 1'b0);
        send_item(REQ_RXBYTE, 8'h00, 1'b0, 8'h00, 1'b0);
        send_item(REQ_BREAK, 8'hff, 1'b1, 8'hff, 1'b1);
        send_item(REQ_RXBYTE, 8'hff, 1'b1, 8'hff, 1'b1);
        send_item(REQ_RXBYTE, 8'hff, 1'b1, SYNC_BYTE, 1'b1);
        send_item(REQ_RXBYTE, 8'hff, 1'b1, 8'hff, 1'b1);
        send_item(REQ_BREAK, 8'h00, 1'b0, 8'h00, 1'b0);
        send_item(REQ_RXBYTE, 8'h00, 1'b0, 8'h12, 1'b0);
        send_item(REQ_RXBYTE, 8'h00, 1'b0, 8'h54, 1'b0);
        send_item(REQ_RXBYTE, 8'h00, 1'b0, 8'h3c, 1'b0);
        send_item(REQ_BREAK, 8'h00, 1'b0, 8'h00, 1'b0);
        send_item(REQ_RXBYTE, 8'h00, 1'b0, 8'h00, 1'b0);
        send_item(REQ_BREAK, 8'h00, 1'b0, 8'h00, 1'b0);
        send_item(REQ_RXBYTE, 8'h00, 1'b0, 8'h00, 1'b0);
        send_item(REQ_RXBYTE, 8'h00, 1'b0, SYNC_BYTE, 1'b0);
        send_item(REQ_RXBYTE, 8'h00, 1'b0, 8'ha5, 1'b0);
    endtask

    task automatic test_master_frames();
        set_mode(1'b1);
        send_item(REQ_BREAK, 8'h00, 1'b0, 8'h00, 1'b0);
        send_item(REQ_RXBYTE, 8'h00, 1'b0, 8'h00, 1'b0);
        send_item(REQ_HEADER, 8'h00, 1'b0, 8'h00, 1'b0);
        send_item(REQ_DATA, 8'h00, 1'b0, 8'hff, 1'b0);
        send_item(REQ_DATA, 8'h00, 1'b0, 8'hff, 1'b0);
        send_item(REQ_DATA, 8'h00, 1'b0, 8'h80, 1'b1);
        send_item(REQ_HEADER, 8'hff, 1'b1, 8'hff, 1'b1);
        send_item(REQ_DATA, 8'h00, 1'b0, 8'h00, 1'b1);
        send_item(REQ_RXBYTE, 8'h00, 1'b0, 8'h00, 1'b0);
        send_item(REQ_RXBYTE, 8'h00, 1'b0, 8'h00, 1'b0);
    endtask

    task automatic test_mode_switch();
        send_item(REQ_HEADER, 8'h5a, 1'b1, 8'h00, 1'b0);
        send_item(REQ_DATA, 8'h00, 1'b0, 8'h10, 1'b0);
        set_mode(1'b0);
        send_item(REQ_RXBYTE, 8'h00, 1'b0, 8'h77, 1'b0);
        send_item(REQ_DATA, 8'h00, 1'b0, 8'h20, 1'b1);
        set_mode(1'b1);
        send_item(REQ_RXBYTE, 8'h00, 1'b0, 8'h00, 1'b0);
    endtask

    task automatic test_backpressure();
        rx_mode = RX_STEADY;
        hold_req = 1;
        send_item(REQ_HEADER, rnd8(), 1'b1, rnd8(), 1'b0);
        for (int k = 0; k < 20; k++)
            send_item(REQ_DATA, rnd8(), 1'($urandom), rnd8(), (k % 5) == 4);
        send_item(REQ_RXBYTE, rnd8(), 1'b0, rnd8(), 1'b0);
        // sender stays off until the output side has caught up
        drain();
        send_item(REQ_HEADER, rnd8(), 1'b0, rnd8(), 1'b0);
        send_item(REQ_DATA, rnd8(), 1'b0, rnd8(), 1'b1);
    endtask

    task automatic test_random(logic master, t_rx_mode rxm, int quota);
        int start;
        set_mode(master);
        rx_mode = rxm;
        start = items_sent;
        burst_left = $urandom_range(1, 12);
        while (items_sent - start < quota) begin
            if ($urandom_range(0, 9) < 7) begin
                if (is_master) master_frame();
                else slave_frame();
            end else begin
                send_noise();
            end
        end
    endtask

    initial begin
        is_master = 1'b0;
        listening = 1'b0;
        pending_id = 8'h00;
        header_phase = HP_IDLE;
        checksum_acc = 8'h00;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_slave_header();
        test_master_frames();
        test_mode_switch();
        test_backpressure();
        test_random(1'b1, RX_RANDOM, 12);
        test_random(1'b0, RX_PATTERN, 12);
        test_random(1'b1, RX_STEADY, 8);
        test_random(1'b0, RX_RANDOM, 6);

        drain();
        repeat (10) @(posedge i_clk);
        $display("%0d byte events sent in both modes, %0d beats checked (%0d id notifications)",
                 items_sent, beats_seen, notifies_seen);
        $display("covered headers, checksums, slave sync errors, break restarts, full stalls");
        if (errors == 0) begin
            $display("tb_lin_frame_byte_engine: done, clean");
        end else begin
            $display("tb_lin_frame_byte_engine: done, errors");
        end
        $finish;
    end

    initial begin
        #1_000_000;
        $display("timeout at %0t", $time);
        $display("tb_lin_frame_byte_engine: done, errors");
        $finish;
    end

endmodule
